// ===== sv/pcr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared constants, types and brush table for the picture command rasterizer.
// ----------------------------------------------------------------------------
package pcr_pkg;

   localparam int PIC_COLS = 160;
   localparam int PIC_ROWS = 168;
   localparam int STORE_DEPTH = PIC_COLS * PIC_ROWS;
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam logic [7:0] MAXX = 8'(PIC_COLS - 1);
   localparam logic [7:0] MAXY = 8'(PIC_ROWS - 1);

   localparam logic [1:0] CMD_FEED    = 2'd0;
   localparam logic [1:0] CMD_CLEAR   = 2'd1;
   localparam logic [1:0] CMD_OVERLAY = 2'd2;
   localparam logic [1:0] CMD_READ    = 2'd3;

   localparam logic [7:0] CLEAR_VALUE = 8'h4F;
   localparam logic [7:0] LFSR_TAPS   = 8'hB8;
   localparam logic [7:0] OP_FIRST    = 8'hF0;

   localparam logic [7:0] OP_SET_VIS = 8'hF0;
   localparam logic [7:0] OP_OFF_VIS = 8'hF1;
   localparam logic [7:0] OP_SET_PRI = 8'hF2;
   localparam logic [7:0] OP_OFF_PRI = 8'hF3;
   localparam logic [7:0] OP_CRN_Y   = 8'hF4;
   localparam logic [7:0] OP_CRN_X   = 8'hF5;
   localparam logic [7:0] OP_ABS     = 8'hF6;
   localparam logic [7:0] OP_REL     = 8'hF7;
   localparam logic [7:0] OP_FILL    = 8'hF8;
   localparam logic [7:0] OP_PEN_SET = 8'hF9;
   localparam logic [7:0] OP_PEN     = 8'hFA;

   localparam logic [4:0] PH_OP = 5'd0, PH_END = 5'd1, PH_ARG_VIS = 5'd2,
      PH_ARG_PRI = 5'd3, PH_ARG_PEN = 5'd4, PH_CRN_X1 = 5'd5, PH_CRN_Y1 = 5'd6,
      PH_CRN_NEXT = 5'd7, PH_ABS_X1 = 5'd8, PH_ABS_Y1 = 5'd9, PH_ABS_X2 = 5'd10,
      PH_ABS_Y2 = 5'd11, PH_REL_X1 = 5'd12, PH_REL_Y1 = 5'd13, PH_REL_STEP = 5'd14,
      PH_FILL_X = 5'd15, PH_FILL_Y = 5'd16, PH_PEN_SEED = 5'd17, PH_PEN_X = 5'd18,
      PH_PEN_Y = 5'd19;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
      logic [7:0] read_x;
      logic [7:0] read_y;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic       picture_ended;
   } rsp_type;

   // one plot request from the sequencer to the pixel unit
   typedef struct packed {
      logic       valid;
      logic [7:0] x;
      logic [7:0] y;
   } plot_type;

   // brush row bits, MSB first; columns tested at bits 15-2k
   function automatic logic [15:0] brush_row(input logic [2:0] size,
                                             input logic [3:0] r);
      logic [15:0] v;
      v = 16'h0000;
      unique case (size)
         3'd0: v = (r == 4'd0) ? 16'h8000 : 16'h0000;
         3'd1: v = (r <= 4'd2) ? 16'hE000 : 16'h0000;
         3'd2: case (r)
               4'd0, 4'd4: v = 16'h7000;
               4'd1, 4'd2, 4'd3: v = 16'hF800;
               default: v = 16'h0000;
            endcase
         3'd3: case (r)
               4'd0, 4'd6: v = 16'h3800;
               4'd1, 4'd5: v = 16'h7C00;
               4'd2, 4'd3, 4'd4: v = 16'hFE00;
               default: v = 16'h0000;
            endcase
         3'd4: case (r)
               4'd0, 4'd8: v = 16'h1C00;
               4'd1, 4'd7: v = 16'h7F00;
               4'd2, 4'd3, 4'd4, 4'd5, 4'd6: v = 16'hFF80;
               default: v = 16'h0000;
            endcase
         3'd5: case (r)
               4'd0, 4'd10: v = 16'h0E00;
               4'd1, 4'd9: v = 16'h3F80;
               4'd2, 4'd3, 4'd7, 4'd8: v = 16'h7FC0;
               4'd4, 4'd5, 4'd6: v = 16'hFFE0;
               default: v = 16'h0000;
            endcase
         3'd6: case (r)
               4'd0, 4'd12: v = 16'h0F80;
               4'd1, 4'd11: v = 16'h3FE0;
               4'd2, 4'd3, 4'd9, 4'd10: v = 16'h7FF0;
               4'd4, 4'd5, 4'd6, 4'd7, 4'd8: v = 16'hFFF8;
               default: v = 16'h0000;
            endcase
         default: case (r)
               4'd0, 4'd14: v = 16'h07C0;
               4'd1, 4'd13: v = 16'h1FF0;
               4'd2, 4'd12: v = 16'h3FF8;
               4'd3, 4'd4, 4'd10, 4'd11: v = 16'h7FFC;
               4'd5, 4'd6, 4'd7, 4'd8, 4'd9: v = 16'hFFFE;
               default: v = 16'h0000;
            endcase
      endcase
      return v;
   endfunction

   function automatic logic [7:0] sat(input logic [7:0] v, input logic [7:0] m);
      return (v > m) ? m : v;
   endfunction

endpackage
`default_nettype wire

// ===== sv/pcr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcr_req_if / pcr_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface pcr_req_if;
   import pcr_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pcr_rsp_if;
   import pcr_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/pcr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcr_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== sv/pcr_pixel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcr_pixel
// Frame store port: clear sweep, pixel read, and (p | mask) & colour update.
// Address is y*PIC_COLS + x from one multiplier, registered.
// ----------------------------------------------------------------------------
module pcr_pixel (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pcr_pkg::plot_type         plot,
   input  wire logic                      read_go,
   input  wire logic                      clear_go,
   input  wire logic [7:0]                mask,
   input  wire logic [7:0]                colour,
   output logic                           busy,
   output logic [7:0]                     rd_value
);
   import pcr_pkg::*;

   localparam logic [1:0] PX_IDLE = 2'd0, PX_READ = 2'd1, PX_WRITE = 2'd2,
      PX_CLEAR = 2'd3;

   logic [1:0]        st_ff, st_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              rd_ff, rd_in;
   logic              wr_en;
   logic [7:0]        wr_data, ram_q;
   logic [ADDR_W-1:0] mul_addr;

   assign mul_addr = ADDR_W'(32'(plot.y) * 32'(PIC_COLS) + 32'(plot.x));

   always_comb begin
      st_in   = st_ff;
      addr_in = addr_ff;
      rd_in   = rd_ff;
      wr_en   = 1'b0;
      wr_data = CLEAR_VALUE;
      unique case (st_ff)
         PX_IDLE: begin
            if (clear_go) begin
               addr_in = '0;
               st_in   = PX_CLEAR;
            end else if (plot.valid || read_go) begin
               addr_in = mul_addr;
               rd_in   = read_go;
               st_in   = PX_READ;
            end
         end
         PX_READ: st_in = rd_ff ? PX_IDLE : PX_WRITE;
         PX_WRITE: begin
            wr_en   = 1'b1;
            wr_data = (ram_q | mask) & colour;
            st_in   = PX_IDLE;
         end
         PX_CLEAR: begin
            wr_en = 1'b1;
            if (addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               st_in = PX_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         default: st_in = PX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= PX_CLEAR;
         addr_ff <= '0;
         rd_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         addr_ff <= addr_in;
         rd_ff   <= rd_in;
      end
   end

   pcr_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (addr_ff),
      .wr_data (wr_data),
      .rd_data (ram_q)
   );

   assign busy     = (st_ff != PX_IDLE);
   assign rd_value = ram_q;
endmodule
`default_nettype wire

// ===== sv/pcr_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcr_seq
// Command parser and drawing sequencer: lines step one pixel per pass, the
// pen steps one brush cell per cycle; each plot waits on the pixel unit.
// ----------------------------------------------------------------------------
module pcr_seq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire pcr_pkg::req_type req,
   input  wire logic             px_busy,
   input  wire logic [7:0]       px_value,
   output pcr_pkg::plot_type     plot,
   output logic                  read_go,
   output logic                  clear_go,
   output logic [7:0]            mask,
   output logic [7:0]            colour,
   output logic                  done,
   output pcr_pkg::rsp_type      rsp
);
   import pcr_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0, S_LINE = 3'd1, S_PEN = 3'd2,
      S_WAIT = 3'd3, S_READ = 3'd4, S_DONE = 3'd5;

   logic [2:0] st_ff, st_in, ret_ff, ret_in;
   logic [4:0] ph_ff, ph_in;
   logic [7:0] col_ff, col_in, msk_ff, msk_in, cx_ff, cx_in, cy_ff, cy_in;
   logic [7:0] pen_ff, pen_in, seed_ff, seed_in, px_ff, px_in;
   logic       cyn_ff, cyn_in;
   // line walker
   logic [8:0] x_ff, x_in, y_ff, y_in, x2_ff, x2_in, y2_ff, y2_in;
   logic [8:0] dx_ff, dx_in, dy_ff, dy_in, wide_ff, wide_in, ax_ff, ax_in;
   logic [8:0] ay_ff, ay_in, n_ff, n_in;
   logic       sx_ff, sx_in, sy_ff, sy_in, str_ff, str_in, first_ff, first_in;
   // pen walker
   logic [8:0] bx_ff, bx_in, by_ff, by_in;
   logic [3:0] r_ff, r_in;
   logic [2:0] k_ff, k_in;
   logic [7:0] lfsr_ff, lfsr_in;
   logic       pv_ff, pv_in;
   logic [7:0] ppx_ff, ppx_in, ppy_ff, ppy_in;
   logic [7:0] out_ff, out_in;
   logic       go_ff, go_in;

   logic [7:0] b, sx8, sy8, relx, rely, lfsr_nx;
   logic [2:0] size;
   logic [3:0] s2;
   logic [8:0] ptx, pty, ax_s, ay_s;
   logic [15:0] row;
   logic        cell_on;

   always_comb begin
      b    = req.data_byte;
      size = pen_ff[2:0];
      s2   = {size, 1'b0};
      row  = brush_row(size, r_ff);
      cell_on = pen_ff[4] | row[4'(15 - 2 * int'(k_ff))];
      lfsr_nx = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : 8'h00);
      relx = b[7] ? (cx_ff - {5'd0, b[6:4]}) : (cx_ff + {5'd0, b[6:4]});
      rely = b[3] ? (cy_ff - {5'd0, b[2:0]}) : (cy_ff + {5'd0, b[2:0]});
      sx8  = sat(b, MAXX);
      sy8  = sat(b, MAXY);
      ax_s = ax_ff + dx_ff;
      ay_s = ay_ff + dy_ff;
      ptx  = '0;
      pty  = '0;

      st_in = st_ff; ret_in = ret_ff; ph_in = ph_ff; col_in = col_ff;
      msk_in = msk_ff; cx_in = cx_ff; cy_in = cy_ff; pen_in = pen_ff;
      seed_in = seed_ff; px_in = px_ff; cyn_in = cyn_ff;
      x_in = x_ff; y_in = y_ff; x2_in = x2_ff; y2_in = y2_ff; dx_in = dx_ff;
      dy_in = dy_ff; wide_in = wide_ff; ax_in = ax_ff; ay_in = ay_ff;
      n_in = n_ff; sx_in = sx_ff; sy_in = sy_ff; str_in = str_ff;
      first_in = first_ff; bx_in = bx_ff; by_in = by_ff; r_in = r_ff;
      k_in = k_ff; lfsr_in = lfsr_ff; pv_in = 1'b0; ppx_in = ppx_ff;
      ppy_in = ppy_ff; out_in = out_ff; go_in = 1'b0;
      clear_go = 1'b0;

      unique case (st_ff)
         S_IDLE: begin
            if (go) begin
               out_in = 8'h00;
               st_in  = S_DONE;
               unique case (req.cmd)
                  CMD_CLEAR, CMD_OVERLAY: begin
                     col_in = 8'hFF; msk_in = '0; cx_in = '0; cy_in = '0;
                     pen_in = '0; seed_in = '0; ph_in = PH_OP; px_in = '0;
                     cyn_in = 1'b0;
                     if (req.cmd == CMD_CLEAR) begin
                        clear_go = 1'b1;
                        st_in    = S_WAIT;
                        ret_in   = S_DONE;
                     end
                  end
                  CMD_READ: begin
                     if (req.read_x < 8'(PIC_COLS) && req.read_y < 8'(PIC_ROWS)) begin
                        ppx_in = req.read_x;
                        ppy_in = req.read_y;
                        go_in  = 1'b1;
                        st_in  = S_READ;
                     end
                  end
                  default: begin
                     // decode the byte; line draws load the walker
                     if (ph_ff == PH_END) begin
                     end else if (ph_ff == PH_OP ||
                                  (ph_ff >= PH_CRN_X1 && b >= OP_FIRST)) begin
                        unique case (b)
                           OP_SET_VIS: ph_in = PH_ARG_VIS;
                           OP_OFF_VIS: begin
                              msk_in = msk_ff & 8'hF0; col_in = col_ff | 8'h0F;
                              ph_in = PH_OP;
                           end
                           OP_SET_PRI: ph_in = PH_ARG_PRI;
                           OP_OFF_PRI: begin
                              msk_in = msk_ff & 8'h0F; col_in = col_ff | 8'hF0;
                              ph_in = PH_OP;
                           end
                           OP_CRN_Y: begin cyn_in = 1'b1; ph_in = PH_CRN_X1; end
                           OP_CRN_X: begin cyn_in = 1'b0; ph_in = PH_CRN_X1; end
                           OP_ABS: ph_in = PH_ABS_X1;
                           OP_REL: ph_in = PH_REL_X1;
                           OP_FILL: ph_in = PH_FILL_X;
                           OP_PEN_SET: ph_in = PH_ARG_PEN;
                           OP_PEN: ph_in = pen_ff[5] ? PH_PEN_SEED : PH_PEN_X;
                           default: ph_in = PH_END;
                        endcase
                     end else begin
                        unique case (ph_ff)
                           PH_ARG_VIS: begin
                              msk_in = msk_ff | 8'h0F;
                              col_in = {col_ff[7:4], b[3:0]}; ph_in = PH_OP;
                           end
                           PH_ARG_PRI: begin
                              msk_in = msk_ff | 8'hF0;
                              col_in = {b[3:0], col_ff[3:0]}; ph_in = PH_OP;
                           end
                           PH_ARG_PEN: begin pen_in = b; ph_in = PH_OP; end
                           PH_CRN_X1, PH_ABS_X1, PH_REL_X1, PH_FILL_X, PH_PEN_X,
                           PH_ABS_X2: begin
                              px_in = sx8; ph_in = ph_ff + 5'd1;
                           end
                           PH_CRN_Y1, PH_ABS_Y1, PH_REL_Y1: begin
                              cx_in = px_ff; cy_in = sy8; ph_in = ph_ff + 5'd1;
                              x2_in = {1'b0, px_ff}; y2_in = {1'b0, sy8};
                              x_in = {1'b0, px_ff}; y_in = {1'b0, sy8};
                              str_in = 1'b1; first_in = 1'b1; st_in = S_LINE;
                           end
                           PH_CRN_NEXT, PH_ABS_Y2, PH_REL_STEP: begin
                              x_in = {1'b0, cx_ff}; y_in = {1'b0, cy_ff};
                              if (ph_ff == PH_CRN_NEXT) begin
                                 x2_in = {1'b0, cyn_ff ? cx_ff : sx8};
                                 y2_in = {1'b0, cyn_ff ? sy8 : cy_ff};
                                 cyn_in = ~cyn_ff;
                              end else if (ph_ff == PH_ABS_Y2) begin
                                 x2_in = {1'b0, px_ff}; y2_in = {1'b0, sy8};
                                 ph_in = PH_ABS_X2;
                              end else begin
                                 x2_in = {1'b0, sat(relx, MAXX)};
                                 y2_in = {1'b0, sat(rely, MAXY)};
                              end
                              first_in = 1'b1; str_in = 1'b0; st_in = S_LINE;
                           end
                           PH_FILL_Y: begin
                              cx_in = px_ff; cy_in = sy8; ph_in = PH_FILL_X;
                           end
                           PH_PEN_SEED: begin seed_in = b; ph_in = PH_PEN_X; end
                           PH_PEN_Y: begin
                              ptx = 9'({px_ff, 1'b0}) - 9'(size);
                              if ({px_ff, 1'b0} < 9'(size)) ptx = '0;
                              if (ptx > 9'(2 * PIC_COLS) - 9'(s2))
                                 ptx = 9'(2 * PIC_COLS) - 9'(s2);
                              pty = {1'b0, sy8} - 9'(size);
                              if (sy8 < 8'(size)) pty = '0;
                              if (pty > 9'(MAXY) - 9'(s2)) pty = 9'(MAXY) - 9'(s2);
                              bx_in = ptx >> 1; by_in = pty;
                              r_in = '0; k_in = '0; lfsr_in = seed_ff | 8'h01;
                              ph_in = pen_ff[5] ? PH_PEN_SEED : PH_PEN_X;
                              st_in = S_PEN;
                           end
                           default: ph_in = PH_END;
                        endcase
                     end
                  end
               endcase
            end
         end
         S_LINE: begin
            ret_in = S_LINE;
            st_in  = S_WAIT;
            if (first_ff) begin
               // setup pass: directions and magnitudes
               first_in = 1'b0;
               sx_in = x2_ff < x_ff; sy_in = y2_ff < y_ff;
               dx_in = (x2_ff < x_ff) ? x_ff - x2_ff : x2_ff - x_ff;
               dy_in = (y2_ff < y_ff) ? y_ff - y2_ff : y2_ff - y_ff;
               cx_in = x2_ff[7:0]; cy_in = y2_ff[7:0];
               if (str_ff) begin
                  // single point plot
                  pv_in = 1'b1; ppx_in = x_ff[7:0]; ppy_in = y_ff[7:0];
                  ret_in = S_DONE;
               end else begin
                  st_in = S_LINE;
                  if (x2_ff == x_ff || y2_ff == y_ff) begin
                     str_in = 1'b1; n_in = '0;
                  end else if (((x2_ff < x_ff) ? x_ff - x2_ff : x2_ff - x_ff) <
                               ((y2_ff < y_ff) ? y_ff - y2_ff : y2_ff - y_ff)) begin
                     wide_in = (y2_ff < y_ff) ? y_ff - y2_ff : y2_ff - y_ff;
                     ax_in = wide_in >> 1; ay_in = '0; n_in = wide_in;
                  end else begin
                     wide_in = (x2_ff < x_ff) ? x_ff - x2_ff : x2_ff - x_ff;
                     ay_in = wide_in >> 1; ax_in = '0; n_in = wide_in;
                  end
               end
            end else if (str_ff) begin
               // axis line: plot, then step unless at end
               pv_in = 1'b1; ppx_in = x_ff[7:0]; ppy_in = y_ff[7:0];
               if (x_ff == x2_ff && y_ff == y2_ff) begin
                  ret_in = S_DONE;
               end else begin
                  if (dx_ff != '0) x_in = sx_ff ? x_ff - 9'd1 : x_ff + 9'd1;
                  if (dy_ff != '0) y_in = sy_ff ? y_ff - 9'd1 : y_ff + 9'd1;
               end
            end else begin
               if (ax_s >= wide_ff) begin
                  ax_in = ax_s - wide_ff; x_in = sx_ff ? x_ff - 9'd1 : x_ff + 9'd1;
               end else ax_in = ax_s;
               if (ay_s >= wide_ff) begin
                  ay_in = ay_s - wide_ff; y_in = sy_ff ? y_ff - 9'd1 : y_ff + 9'd1;
               end else ay_in = ay_s;
               pv_in = 1'b1; ppx_in = x_in[7:0]; ppy_in = y_in[7:0];
               n_in = n_ff - 9'd1;
               if (n_ff == 9'd1) ret_in = S_DONE;
            end
         end
         S_PEN: begin
            if (k_ff == size) begin
               k_in = '0; r_in = r_ff + 4'd1;
            end else begin
               k_in = k_ff + 3'd1;
            end
            if (cell_on) begin
               if (pen_ff[5]) lfsr_in = lfsr_nx;
               if (!pen_ff[5] || lfsr_nx[1:0] == 2'b01) begin
                  ppx_in = 8'(bx_ff + 9'(k_ff));
                  ppy_in = 8'(by_ff + 9'(r_ff));
                  pv_in = (bx_ff + 9'(k_ff)) < 9'(PIC_COLS);
               end
            end
            if (k_ff == size && r_ff == s2) begin
               st_in = pv_in ? S_WAIT : S_DONE;
               ret_in = S_DONE;
            end else if (pv_in) begin
               st_in = S_WAIT; ret_in = S_PEN;
            end
         end
         S_WAIT: begin
            if (!px_busy && !pv_ff && !go_ff) st_in = ret_ff;
         end
         S_READ: begin
            ret_in = S_READ;
            if (!px_busy && !go_ff && !pv_ff) begin
               out_in = px_value; st_in = S_DONE;
            end
         end
         S_DONE: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ret_ff <= S_IDLE; ph_ff <= PH_OP; col_ff <= 8'hFF;
         msk_ff <= '0; cx_ff <= '0; cy_ff <= '0; pen_ff <= '0; seed_ff <= '0;
         px_ff <= '0; cyn_ff <= 1'b0; pv_ff <= 1'b0; go_ff <= 1'b0;
         first_ff <= 1'b0; str_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ret_ff <= ret_in; ph_ff <= ph_in; col_ff <= col_in;
         msk_ff <= msk_in; cx_ff <= cx_in; cy_ff <= cy_in; pen_ff <= pen_in;
         seed_ff <= seed_in; px_ff <= px_in; cyn_ff <= cyn_in; pv_ff <= pv_in;
         go_ff <= go_in; first_ff <= first_in; str_ff <= str_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; x2_ff <= x2_in; y2_ff <= y2_in;
      dx_ff <= dx_in; dy_ff <= dy_in; wide_ff <= wide_in; ax_ff <= ax_in;
      ay_ff <= ay_in; n_ff <= n_in; sx_ff <= sx_in; sy_ff <= sy_in;
      bx_ff <= bx_in; by_ff <= by_in; r_ff <= r_in; k_ff <= k_in;
      lfsr_ff <= lfsr_in; ppx_ff <= ppx_in; ppy_ff <= ppy_in; out_ff <= out_in;
   end

   assign plot.valid = pv_ff;
   assign plot.x     = ppx_ff;
   assign plot.y     = ppy_ff;
   assign mask       = msk_ff;
   assign colour     = col_ff;
   assign done       = (st_ff == S_DONE);
   assign rsp.pixel_value   = out_ff;
   assign rsp.picture_ended = (ph_ff == PH_END);
   // read uses the plot address path with the write suppressed
   assign read_go = go_ff;
endmodule
`default_nettype wire

// ===== sv/picture_command_rasterizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// picture_command_rasterizer
// Decodes a vector picture byte stream and draws it into a frame store.
// ----------------------------------------------------------------------------
// channel  dir  fields
// req      in   cmd, data_byte, read_x, read_y
// rsp      out  pixel_value, picture_ended
//
// Each plotted pixel costs one sequencer pass and a read-modify-write of the
// single frame store port. After reset, and on a clear request, a sweep over
// all PIC_COLS*PIC_ROWS addresses fills the store while req.ready stays low.
// The result is held in an output register until taken; the next request
// waits for that.
// ----------------------------------------------------------------------------
module picture_command_rasterizer (
   input  wire logic clock,
   input  wire logic reset,
   pcr_req_if.sink   req,
   pcr_rsp_if.source rsp
);
   import pcr_pkg::*;

   plot_type   plot_w, plot_mux;
   logic       read_go, clear_go, px_busy, seq_done, go;
   logic [7:0] px_value, mask, colour;
   rsp_type    seq_rsp, rsp_ff;
   logic       rsp_valid_ff, busy_ff;

   assign req.ready = !busy_ff && !rsp_valid_ff && !px_busy;
   assign go = req.valid && req.ready;

   pcr_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .req      (req.payload),
      .px_busy  (px_busy),
      .px_value (px_value),
      .plot     (plot_w),
      .read_go  (read_go),
      .clear_go (clear_go),
      .mask     (mask),
      .colour   (colour),
      .done     (seq_done),
      .rsp      (seq_rsp)
   );

   assign plot_mux = plot_w;

   pcr_pixel u_pixel (
      .clock    (clock),
      .reset    (reset),
      .plot     (plot_mux),
      .read_go  (read_go),
      .clear_go (clear_go),
      .mask     (mask),
      .colour   (colour),
      .busy     (px_busy),
      .rd_value (px_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go) busy_ff <= 1'b1;
         else if (seq_done) busy_ff <= 1'b0;
         if (seq_done) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done) rsp_ff <= seq_rsp;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.ready) else $error("request taken while busy");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> busy_ff) else $error("result without request");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      seq_done |=> rsp.valid) else $error("result lost");
endmodule
`default_nettype wire
